### hdl/vfsc_pkg.sv
package vfsc_pkg;

  localparam int unsigned SECTOR_BYTES = 512;

  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SPC_W      = 17;
  localparam int unsigned CB_W       = 26;
  localparam int unsigned BYTES_W    = 58;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CB_PROD_W  = SPC_W + $clog2(SECTOR_BYTES + 1);

  localparam logic [CB_PROD_W-1:0] MAX_CLUSTER_BYTES = CB_PROD_W'(33554432);

  localparam logic [CFG_IDX_W-1:0] REG_FS_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPC           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNTED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FSINFO_VALID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FSINFO_FREE   = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNMOUNTED = 2'd1;
  localparam logic [1:0] STATUS_SHORT     = 2'd2;

  localparam logic CMD_QUERY   = 1'b0;
  localparam logic FS_FAT      = 1'b0;

  typedef struct packed {
    logic             cmd;
    logic [CNT_W-1:0] entry;
    logic             last;
  } vfsc_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               from_cache;
    logic [CNT_W-1:0]   free_clus;
    logic [CNT_W-1:0]   used_clus;
    logic [CNT_W-1:0]   total_clus;
    logic [CB_W-1:0]    cluster_bytes;
    logic [BYTES_W-1:0] free_size;
    logic [BYTES_W-1:0] used_size;
    logic [BYTES_W-1:0] total_size;
  } vfsc_out_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             from_cache;
    logic [CNT_W-1:0] free_clus;
    logic [CNT_W-1:0] used_clus;
    logic [CNT_W-1:0] total_clus;
    logic [CB_W-1:0]  cluster_bytes;
  } vfsc_fig_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

### hdl/vfsc_scale.sv
module vfsc_scale
  import vfsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  vfsc_fig_t fig_i,
  output logic      valid_o,
  output vfsc_out_t data_o
);

  logic      valid_q;
  vfsc_out_t data_d;
  vfsc_out_t data_q;

  always_comb begin
    data_d.status        = fig_i.status;
    data_d.from_cache    = fig_i.from_cache;
    data_d.free_clus     = fig_i.free_clus;
    data_d.used_clus     = fig_i.used_clus;
    data_d.total_clus    = fig_i.total_clus;
    data_d.cluster_bytes = fig_i.cluster_bytes;
    data_d.free_size     = BYTES_W'(fig_i.free_clus) * BYTES_W'(fig_i.cluster_bytes);
    data_d.used_size     = BYTES_W'(fig_i.used_clus) * BYTES_W'(fig_i.cluster_bytes);
    data_d.total_size    = BYTES_W'(fig_i.total_clus) * BYTES_W'(fig_i.cluster_bytes);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/volume_free_space_counter_core.sv
// Volume free space counter.
// Input channel (in_valid_i, in_stall_o, in_data_i): a transfer with cmd clear starts a
// query; a transfer with cmd set carries one scan element (a FAT entry, or an exFAT
// bitmap byte in the low eight bits), with last set on the final element.
// A query on an unmounted volume, a FAT query with a known free count and a query
// with no elements to scan report at once; otherwise the query opens a scan and the
// report follows the element marked last. Elements with no open scan produce nothing.
// Output channel (out_valid_o, out_stall_i, out_data_o): one transfer per report with
// status, cluster counts, cluster size and byte figures.
// out_valid_o is registered: the report passes one register stage for the scan state
// update and count selection, then one for the three byte multipliers.
// Throughput is one input transfer per cycle while the receiver does not stall a report.
// When the receiver stalls with a report waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle; no report is dropped.
// Reset clears the scan state and the cached free count and loads the register
// reset values. The user writes registers via cfg_we_i, cfg_idx_i and cfg_wdata_i only while
// idle (not enforced); writing the mode or the cluster count forgets the cache.
module volume_free_space_counter_core
  import vfsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vfsc_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output vfsc_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic             fs_mode_q;
  logic [CNT_W-1:0] cluster_count_q;
  logic [SPC_W-1:0] spc_q;
  logic             mounted_q;
  logic             fsinfo_valid_q;
  logic [CNT_W-1:0] fsinfo_free_q;

  logic [CNT_W-1:0] running_count_q, running_count_d;
  logic [CNT_W-1:0] element_index_q, element_index_d;
  logic             scan_active_q, scan_active_d;
  logic [CNT_W-1:0] cached_free_q, cached_free_d;
  logic             cache_known_q, cache_known_d;

  logic             en;
  logic             accept;
  logic [CNT_W-1:0] expected;
  logic             idx_lt;
  logic [CNT_W-1:0] idx_inc;
  logic             tail;
  logic [7:0]       tail_mask;
  logic [3:0]       inc;
  logic [CNT_W-1:0] rc_new;
  logic [CNT_W-1:0] rc_clamp;
  logic [CNT_W-1:0] fin_free;
  logic [CNT_W-1:0] cache_src;
  logic [CNT_W-1:0] cache_clamp;
  logic [SPC_W-1:0]     spc_eff;
  logic [CB_PROD_W-1:0] cb_prod;
  logic [CB_W-1:0]      cb_sat;

  logic             emit;
  logic             fig_ok;
  logic [1:0]       fig_status;
  logic             fig_cache;
  logic [CNT_W-1:0] free_sel;

  logic      s1_valid_q;
  vfsc_fig_t s1_d, s1_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  assign expected = fs_mode_q
                  ? ({3'b000, cluster_count_q[CNT_W-1:3]} + CNT_W'(|cluster_count_q[2:0]))
                  : cluster_count_q;
  assign idx_lt   = element_index_q < expected;
  assign idx_inc  = element_index_q + CNT_W'(1);
  assign tail     = (cluster_count_q[2:0] != 3'd0)
                 && (element_index_q == {3'b000, cluster_count_q[CNT_W-1:3]});

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail_mask[b] = !tail || (3'(b) < cluster_count_q[2:0]);
    end
  end

  assign inc = fs_mode_q ? popcount8(in_data_i.entry[7:0] & tail_mask)
                         : 4'(in_data_i.entry == '0);
  assign rc_new      = running_count_q + (idx_lt ? CNT_W'(inc) : '0);
  assign rc_clamp    = (rc_new > cluster_count_q) ? cluster_count_q : rc_new;
  assign fin_free    = fs_mode_q ? (cluster_count_q - rc_clamp) : rc_clamp;
  assign cache_src   = cache_known_q ? cached_free_q : fsinfo_free_q;
  assign cache_clamp = (cache_src > cluster_count_q) ? cluster_count_q : cache_src;

  assign spc_eff = (spc_q == '0) ? SPC_W'(1) : spc_q;
  assign cb_prod = CB_PROD_W'(spc_eff) * CB_PROD_W'(SECTOR_BYTES);
  assign cb_sat  = (cb_prod > MAX_CLUSTER_BYTES) ? CB_W'(MAX_CLUSTER_BYTES) : CB_W'(cb_prod);

  always_comb begin
    running_count_d = running_count_q;
    element_index_d = element_index_q;
    scan_active_d   = scan_active_q;
    cached_free_d   = cached_free_q;
    cache_known_d   = cache_known_q;
    emit            = 1'b0;
    fig_ok          = 1'b0;
    fig_status      = STATUS_OK;
    fig_cache       = 1'b0;
    free_sel        = '0;
    if (accept) begin
      if (in_data_i.cmd == CMD_QUERY) begin
        scan_active_d = 1'b0;
        if (!mounted_q) begin
          emit       = 1'b1;
          fig_status = STATUS_UNMOUNTED;
        end else if (fs_mode_q == FS_FAT && (cache_known_q || fsinfo_valid_q)) begin
          emit      = 1'b1;
          fig_ok    = 1'b1;
          fig_cache = 1'b1;
          free_sel  = cache_clamp;
        end else begin
          running_count_d = '0;
          element_index_d = '0;
          scan_active_d   = 1'b1;
          if (expected == '0) begin
            scan_active_d = 1'b0;
            emit          = 1'b1;
            fig_ok        = 1'b1;
            if (fs_mode_q == FS_FAT) begin
              cached_free_d = '0;
              cache_known_d = 1'b1;
            end
          end
        end
      end else if (scan_active_q) begin
        if (!mounted_q) begin
          scan_active_d = 1'b0;
          emit          = 1'b1;
          fig_status    = STATUS_UNMOUNTED;
        end else begin
          if (idx_lt) begin
            running_count_d = rc_new;
            element_index_d = idx_inc;
          end
          if (in_data_i.last) begin
            scan_active_d = 1'b0;
            emit          = 1'b1;
            if (idx_lt && idx_inc != expected) begin
              fig_status = STATUS_SHORT;
            end else begin
              fig_ok   = 1'b1;
              free_sel = fin_free;
              if (fs_mode_q == FS_FAT) begin
                cached_free_d = fin_free;
                cache_known_d = 1'b1;
              end
            end
          end
        end
      end
    end
    if (cfg_we_i && (cfg_idx_i == REG_FS_MODE || cfg_idx_i == REG_CLUSTER_COUNT)) begin
      cache_known_d = 1'b0;
    end
  end

  always_comb begin
    s1_d.status        = fig_status;
    s1_d.from_cache    = fig_cache;
    s1_d.free_clus     = fig_ok ? free_sel : '0;
    s1_d.used_clus     = fig_ok ? (cluster_count_q - free_sel) : '0;
    s1_d.total_clus    = fig_ok ? cluster_count_q : '0;
    s1_d.cluster_bytes = fig_ok ? cb_sat : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_mode_q       <= 1'b0;
      cluster_count_q <= '0;
      spc_q           <= SPC_W'(1);
      mounted_q       <= 1'b0;
      fsinfo_valid_q  <= 1'b0;
      fsinfo_free_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FS_MODE:       fs_mode_q       <= cfg_wdata_i[0];
        REG_CLUSTER_COUNT: cluster_count_q <= cfg_wdata_i;
        REG_SPC:           spc_q           <= cfg_wdata_i[SPC_W-1:0];
        REG_MOUNTED:       mounted_q       <= cfg_wdata_i[0];
        REG_FSINFO_VALID:  fsinfo_valid_q  <= cfg_wdata_i[0];
        REG_FSINFO_FREE:   fsinfo_free_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_count_q <= '0;
      element_index_q <= '0;
      scan_active_q   <= 1'b0;
      cached_free_q   <= '0;
      cache_known_q   <= 1'b0;
      s1_valid_q      <= 1'b0;
    end else begin
      running_count_q <= running_count_d;
      element_index_q <= element_index_d;
      scan_active_q   <= scan_active_d;
      cached_free_q   <= cached_free_d;
      cache_known_q   <= cache_known_d;
      if (en) begin
        s1_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit) begin
      s1_q <= s1_d;
    end
  end

  vfsc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .fig_i   (s1_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // An error report carries no figures.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |->
      !out_data_o.from_cache && out_data_o.total_size == '0
      && out_data_o.free_clus == '0)
    else $error("error report carries figures");

  // Free and used clusters always add up to the total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_OK |->
      ({1'b0, out_data_o.free_clus} + {1'b0, out_data_o.used_clus})
        == {1'b0, out_data_o.total_clus})
    else $error("free plus used differs from total");

  // Any report closes the scan that produced it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept) && $past(emit) |-> !scan_active_q)
    else $error("scan still open after a report");

  // A stall of the receiver stops input transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while the output is stalled");

endmodule

### tb/tb_volume_free_space_counter_core.sv
module tb_volume_free_space_counter_core
  import vfsc_pkg::*;
;

  localparam logic CMD_SCAN = 1'b1;
  localparam logic FS_EXFAT = 1'b1;

  class space_report_board;
    bit        fs_mode;
    bit [31:0] cluster_count;
    bit [16:0] spc;
    bit        mounted;
    bit        fsinfo_valid;
    bit [31:0] fsinfo_free;
    bit [31:0] run_count;
    bit [31:0] elem_idx;
    bit        scanning;
    bit [31:0] cached_free;
    bit        cache_known;
    vfsc_out_t pending_reports[$];
    int        n_checked;
    int        n_errors;
    int        n_cached;
    int        n_unmounted;
    int        n_short;

    function new();
      spc = 17'd1;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
      case (idx)
        REG_FS_MODE: begin
          fs_mode = val[0];
          cache_known = 1'b0;
        end
        REG_CLUSTER_COUNT: begin
          cluster_count = val;
          cache_known = 1'b0;
        end
        REG_SPC: spc = val[16:0];
        REG_MOUNTED: mounted = val[0];
        REG_FSINFO_VALID: fsinfo_valid = val[0];
        REG_FSINFO_FREE: fsinfo_free = val;
        default: ;
      endcase
    endfunction

    function bit [31:0] expected_count();
      if (fs_mode != FS_FAT) begin
        return (cluster_count >> 3) + ((cluster_count[2:0] != 3'd0) ? 32'd1 : 32'd0);
      end
      return cluster_count;
    endfunction

    function vfsc_out_t error_report(input logic [1:0] status);
      vfsc_out_t r;
      r = '0;
      r.status = status;
      return r;
    endfunction

    function vfsc_out_t figures(input bit [31:0] free_cl, input bit cached);
      bit [63:0] cb;
      vfsc_out_t r;
      cb = (spc == 17'd0) ? 64'(SECTOR_BYTES) : 64'(spc) * SECTOR_BYTES;
      if (cb > 64'(MAX_CLUSTER_BYTES)) begin
        cb = 64'(MAX_CLUSTER_BYTES);
      end
      if (free_cl > cluster_count) begin
        free_cl = cluster_count;
      end
      r.status = STATUS_OK;
      r.from_cache = cached;
      r.free_clus = free_cl;
      r.used_clus = cluster_count - free_cl;
      r.total_clus = cluster_count;
      r.cluster_bytes = cb[CB_W-1:0];
      r.free_size = BYTES_W'(64'(free_cl) * cb);
      r.used_size = BYTES_W'(64'(cluster_count - free_cl) * cb);
      r.total_size = BYTES_W'(64'(cluster_count) * cb);
      return r;
    endfunction

    function vfsc_out_t finish_scan();
      bit [31:0] free_cl;
      bit [31:0] used;
      scanning = 1'b0;
      if (fs_mode != FS_FAT) begin
        used = (run_count > cluster_count) ? cluster_count : run_count;
        free_cl = cluster_count - used;
      end else begin
        free_cl = (run_count > cluster_count) ? cluster_count : run_count;
        cached_free = free_cl;
        cache_known = 1'b1;
      end
      return figures(free_cl, 1'b0);
    endfunction

    function void note_transfer(input vfsc_in_t it);
      bit [31:0] n_exp;
      bit [7:0]  b;
      bit [2:0]  rem;
      if (it.cmd == CMD_QUERY) begin
        scanning = 1'b0;
        if (!mounted) begin
          pending_reports.push_back(error_report(STATUS_UNMOUNTED));
          return;
        end
        if (fs_mode == FS_FAT) begin
          if (cache_known) begin
            pending_reports.push_back(figures(cached_free, 1'b1));
            return;
          end
          if (fsinfo_valid) begin
            pending_reports.push_back(figures(fsinfo_free, 1'b1));
            return;
          end
        end
        run_count = '0;
        elem_idx = '0;
        scanning = 1'b1;
        if (expected_count() == 32'd0) begin
          pending_reports.push_back(finish_scan());
        end
        return;
      end
      if (!scanning) begin
        return;
      end
      if (!mounted) begin
        scanning = 1'b0;
        pending_reports.push_back(error_report(STATUS_UNMOUNTED));
        return;
      end
      n_exp = expected_count();
      if (elem_idx < n_exp) begin
        if (fs_mode != FS_FAT) begin
          b = it.entry[7:0];
          rem = cluster_count[2:0];
          if (rem != 3'd0 && elem_idx == (cluster_count >> 3)) begin
            b &= 8'((1 << rem) - 1);
          end
          run_count += $countones(b);
        end else if (it.entry == 32'd0) begin
          run_count++;
        end
        elem_idx++;
      end
      if (!it.last) begin
        return;
      end
      if (elem_idx < n_exp) begin
        scanning = 1'b0;
        pending_reports.push_back(error_report(STATUS_SHORT));
        return;
      end
      pending_reports.push_back(finish_scan());
    endfunction

    function void match_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_report(input vfsc_out_t got);
      vfsc_out_t want;
      if (pending_reports.size() == 0) begin
        $error("report transfer with no report expected");
        n_errors++;
        return;
      end
      want = pending_reports.pop_front();
      n_checked++;
      if (want.status == STATUS_UNMOUNTED) n_unmounted++;
      if (want.status == STATUS_SHORT) n_short++;
      if (want.from_cache) n_cached++;
      match_field("status", 64'(want.status), 64'(got.status));
      match_field("from_cache", 64'(want.from_cache), 64'(got.from_cache));
      match_field("free_clus", 64'(want.free_clus), 64'(got.free_clus));
      match_field("used_clus", 64'(want.used_clus), 64'(got.used_clus));
      match_field("total_clus", 64'(want.total_clus), 64'(got.total_clus));
      match_field("cluster_bytes", 64'(want.cluster_bytes), 64'(got.cluster_bytes));
      match_field("free_size", 64'(want.free_size), 64'(got.free_size));
      match_field("used_size", 64'(want.used_size), 64'(got.used_size));
      match_field("total_size", 64'(want.total_size), 64'(got.total_size));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  vfsc_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  vfsc_out_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  space_report_board board = new();
  int n_in;
  int n_sent;
  int n_writes;
  int n_phases;
  bit tx_idle;
  bit rx_idle;
  bit long_hold;
  bit stim_cached;

  volume_free_space_counter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_report(out_data_o);
      end
      if (in_valid_i && !in_stall_o) begin
        board.note_transfer(in_data_i);
        n_in++;
      end
    end
  end

  initial begin
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        gap = 200;
        long_hold = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    #5_000_000;
    $error("run did not finish in time");
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [31:0] entry, input logic last);
    vfsc_in_t it;
    int gap;
    it.cmd = cmd;
    it.entry = entry;
    it.last = last;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    n_writes++;
    if (idx == REG_FS_MODE || idx == REG_CLUSTER_COUNT) begin
      stim_cached = 1'b0;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0, 1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3: return $urandom_range(1, 8);
      default: return (board.fs_mode == FS_FAT) ? $urandom_range(1, 48) : $urandom_range(1, 200);
    endcase
  endfunction

  function automatic logic [31:0] pick_spc();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd65536;
      3: return 32'h1_FFFF;
      4: return 32'($urandom_range(0, 17'h1_FFFF));
      default: return $urandom_range(1, 128);
    endcase
  endfunction

  task automatic send_elems(input int n, input bit with_last);
    for (int i = 0; i < n; i++) begin
      send_item(CMD_SCAN, rand_entry(), with_last && (i == n - 1));
    end
  endtask

  task automatic random_phase();
    int n_seq;
    int kind;
    int lim;
    bit [31:0] n_exp;
    bit scan_needed;
    settle();
    n_phases++;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1) == 0) write_reg(REG_FS_MODE, $urandom_range(0, 1));
    if ($urandom_range(0, 9) < 6) write_reg(REG_CLUSTER_COUNT, pick_count());
    if ($urandom_range(0, 9) < 3) write_reg(REG_SPC, pick_spc());
    if ($urandom_range(0, 9) < 3) write_reg(REG_MOUNTED, ($urandom_range(0, 4) != 0));
    if ($urandom_range(0, 9) < 4) write_reg(REG_FSINFO_VALID, $urandom_range(0, 1));
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_FSINFO_FREE, 32'hFFFF_FFFF);
        1, 2: write_reg(REG_FSINFO_FREE, $urandom());
        default: write_reg(REG_FSINFO_FREE, $urandom_range(0, 50));
      endcase
    end
    n_exp = board.expected_count();
    n_seq = $urandom_range(1, 6);
    repeat (n_seq) begin
      kind = $urandom_range(0, 99);
      scan_needed = board.mounted &&
                    (board.fs_mode != FS_FAT || (!stim_cached && !board.fsinfo_valid));
      if (kind >= 95) begin
        send_elems($urandom_range(1, 3), $urandom_range(0, 1));
      end else begin
        send_item(CMD_QUERY, rand_entry(), $urandom_range(0, 1));
        if (!scan_needed || n_exp == 32'd0) begin
          if (kind < 10) send_elems(1, $urandom_range(0, 1));
        end else if (kind < 70 && n_exp <= 32'd64) begin
          send_elems(int'(n_exp) + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0),
                     1'b1);
          if (board.fs_mode == FS_FAT) stim_cached = 1'b1;
        end else if (n_exp >= 32'd2 && kind < 88) begin
          lim = (n_exp > 32'd7) ? 6 : int'(n_exp) - 1;
          send_elems($urandom_range(1, lim), 1'b1);
        end else begin
          lim = (n_exp > 32'd6) ? 6 : int'(n_exp);
          send_elems($urandom_range(0, lim), 1'b0);
        end
      end
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'hFFFF_FFFF, 1'b1);
    settle();
    write_reg(REG_MOUNTED, 32'd1);
    write_reg(REG_CLUSTER_COUNT, 32'd5);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_SCAN, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd1, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b1);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    settle();
    write_reg(REG_CLUSTER_COUNT, 32'd4);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b1);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b0);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd5, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b1);
    settle();
    write_reg(REG_CLUSTER_COUNT, 32'd3);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_elems(4, 1'b0);
    send_item(CMD_SCAN, 32'd0, 1'b1);
    settle();
    write_reg(REG_CLUSTER_COUNT, 32'd0);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    settle();
    write_reg(REG_CLUSTER_COUNT, 32'hFFFF_FFFF);
    write_reg(REG_FSINFO_FREE, 32'hFFFF_FFFF);
    write_reg(REG_FSINFO_VALID, 32'd1);
    write_reg(REG_SPC, 32'h1_FFFF);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    settle();
    write_reg(REG_SPC, 32'd0);
    write_reg(REG_FS_MODE, FS_EXFAT);
    write_reg(REG_CLUSTER_COUNT, 32'd11);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'h1234_56FF, 1'b0);
    send_item(CMD_SCAN, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'h0000_0081, 1'b0);
    settle();
    write_reg(REG_MOUNTED, 32'd0);
    send_item(CMD_SCAN, 32'h0000_00FF, 1'b0);
    settle();
    write_reg(REG_MOUNTED, 32'd1);
    send_item(CMD_QUERY, 32'd0, 1'b0);
    send_item(CMD_SCAN, 32'h0000_00AA, 1'b0);
    settle();
    write_reg(REG_CLUSTER_COUNT, 32'd20);
    send_item(CMD_SCAN, 32'h0000_000F, 1'b0);
    send_item(CMD_SCAN, 32'h0000_00FF, 1'b1);
    settle();

    write_reg(REG_FS_MODE, FS_FAT);
    write_reg(REG_CLUSTER_COUNT, 32'd20);
    write_reg(REG_SPC, 32'd8);
    write_reg(REG_FSINFO_FREE, 32'd7);
    tx_idle = 1'b0;
    long_hold = 1'b1;
    repeat (40) send_item(CMD_QUERY, $urandom(), $urandom_range(0, 1));
    settle();

    while (n_sent < 1400) begin
      random_phase();
    end
    settle();

    $display("Checked %0d reports (%0d from cache, %0d unmounted, %0d short scans)",
             board.n_checked, board.n_cached, board.n_unmounted, board.n_short);
    $display("for %0d input transfers, using %0d register writes over %0d random setups.",
             n_in, n_writes, n_phases);
    if (board.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
